@@ rtl/core/hnf_pkg.sv @@
// hnf_pkg: shared widths, constants, octave weight table and lane type
// for the hash noise fbm block; no dependencies
package hnf_pkg;

  localparam int CoordW  = 18;
  localparam int SumW    = 22;
  localparam int IntW    = 10;
  localparam int HashW   = 17;
  localparam int MagW    = 17;
  localparam int WeightW = 19;
  localparam int TableN  = 16;

  // floor(3*v/10) == (v * ScaleMul) >> ScaleShift for 18-bit v
  localparam int ScaleShift = 23;
  localparam logic [21:0] ScaleMul = 22'd2516583;

  localparam logic [5:0]  HashRowMul = 6'd57;
  localparam logic [31:0] HashMulA   = 32'd15731;
  localparam logic [31:0] HashAddA   = 32'd789221;
  localparam logic [31:0] HashAddB   = 32'd1376312589;
  localparam logic [MagW-1:0] MagOne = 17'd65536;
  localparam logic [SumW-1:0] SumMax = '1;

  typedef logic [WeightW-1:0] weight_t;

  // 0.3^(-0.1*i) in UQ3.16
  localparam weight_t WEIGHT_Q16 [TableN] = '{
    19'd65536,  19'd73921,  19'd83379,  19'd94047,
    19'd106079, 19'd119652, 19'd134961, 19'd152228,
    19'd171705, 19'd193674, 19'd218453, 19'd246403,
    19'd277929, 19'd313489, 19'd353598, 19'd398839
  };

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SumW-1:0]   sum;
  } lane_t;

endpackage

@@ rtl/core/hnf_cell.sv @@
// hnf_cell: one octave of the fbm chain, six register stages
// hashes the lattice point, adds the weighted magnitude, scales the coordinate
// depends on hnf_pkg
module hnf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  hnf_pkg::lane_t  in_lane,
  input  hnf_pkg::weight_t weight,
  output logic            out_valid,
  output hnf_pkg::lane_t  out_lane
);
  import hnf_pkg::*;

  logic [4:0] vld;

  logic [IntW-1:0]  ix;
  logic [IntW-1:0]  iy;
  logic [15:0]      row;
  logic [15:0]      n0;
  logic [HashW-1:0] n1;
  logic [39:0]      xp;
  logic [39:0]      yp;
  lane_t            lane0;

  logic [HashW-1:0] s1_n;
  lane_t            s1_lane;
  logic [33:0]      nsq;
  logic [31:0]      s2_nn;
  logic [HashW-1:0] s2_n;
  lane_t            s2_lane;
  logic [31:0]      s3_t;
  logic [HashW-1:0] s3_n;
  lane_t            s3_lane;
  logic [31:0]      s4_p;
  lane_t            s4_lane;
  logic [31:0]      m;
  logic [MagW-1:0]  q;
  logic [MagW-1:0]  mag;
  logic [MagW-1:0]  s5_mag;
  lane_t            s5_lane;
  logic [35:0]      tprod;
  logic [SumW:0]    sum_ext;

  // lattice hash input and coordinate scaling
  always_comb begin
    ix  = in_lane.x[CoordW-1:CoordW-IntW];
    iy  = in_lane.y[CoordW-1:CoordW-IntW];
    row = {6'd0, iy} * {10'd0, HashRowMul};
    n0  = {6'd0, ix} + row;
    n1  = {n0, 1'b0} ^ {1'b0, n0};
    xp  = {22'd0, in_lane.x} * {18'd0, ScaleMul};
    yp  = {22'd0, in_lane.y} * {18'd0, ScaleMul};
    lane0.x   = {1'b0, xp[39:ScaleShift]};
    lane0.y   = {1'b0, yp[39:ScaleShift]};
    lane0.sum = in_lane.sum;
  end

  assign nsq = {17'd0, s1_n} * {17'd0, s1_n};

  always_comb begin
    m   = s4_p + HashAddB;
    q   = m[30:14];
    mag = (q <= MagOne) ? (MagOne - q) : (q - MagOne);
    tprod   = {19'd0, s5_mag} * {17'd0, weight};
    sum_ext = {1'b0, s5_lane.sum} + {3'd0, tprod[35:16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[3:0], in_valid};
      out_valid <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_n    <= n1;
      s1_lane <= lane0;
      s2_nn   <= nsq[31:0];
      s2_n    <= s1_n;
      s2_lane <= s1_lane;
      s3_t    <= s2_nn * HashMulA + HashAddA;
      s3_n    <= s2_n;
      s3_lane <= s2_lane;
      s4_p    <= {15'd0, s3_n} * s3_t;
      s4_lane <= s3_lane;
      s5_mag  <= mag;
      s5_lane <= s4_lane;
      out_lane.x   <= s5_lane.x;
      out_lane.y   <= s5_lane.y;
      out_lane.sum <= sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
    end
  end

endmodule

@@ rtl/core/hash_noise_fbm.sv @@
// hash_noise_fbm: top level, a chain of OCTAVES hnf_cell octave cells
// followed by an output register with a skid stage
// depends on hnf_pkg and hnf_cell
//
// One coordinate beat in, one fbm_sum beat out, at a sustained rate of one
// beat per clock while the chain is not stopped. Each octave is one cell of
// six register stages, the first loaded at acceptance, and a beat passes
// through every cell before the output register. The chain only stops when
// the output register and the skid stage both hold a result; coord_ready
// then drops until fbm_ready drains the skid stage.
module hash_noise_fbm #(
  parameter int OCTAVES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      coord_valid,
  output logic                      coord_ready,
  input  logic [hnf_pkg::CoordW-1:0] coord_x,
  input  logic [hnf_pkg::CoordW-1:0] coord_y,
  output logic                      fbm_valid,
  input  logic                      fbm_ready,
  output logic [hnf_pkg::SumW-1:0]  fbm_sum
);
  import hnf_pkg::*;

  logic            chain_valid [OCTAVES+1];
  lane_t           chain_lane  [OCTAVES+1];
  logic            en;
  logic            skid_valid;
  logic [SumW-1:0] skid_sum;
  logic            out_free;

  assign en          = !skid_valid;
  assign coord_ready = en;
  assign out_free    = !fbm_valid || fbm_ready;

  assign chain_valid[0]    = coord_valid;
  assign chain_lane[0].x   = coord_x;
  assign chain_lane[0].y   = coord_y;
  assign chain_lane[0].sum = '0;

  for (genvar i = 0; i < OCTAVES; i++) begin : g_cell
    hnf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_lane   (chain_lane[i]),
      .weight    (WEIGHT_Q16[i]),
      .out_valid (chain_valid[i+1]),
      .out_lane  (chain_lane[i+1])
    );
  end

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fbm_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        fbm_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      fbm_valid <= chain_valid[OCTAVES];
    end else if (chain_valid[OCTAVES]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        fbm_sum <= skid_sum;
      end
    end else if (out_free) begin
      fbm_sum <= chain_lane[OCTAVES].sum;
    end else begin
      skid_sum <= chain_lane[OCTAVES].sum;
    end
  end

endmodule

@@ bench/testbench.sv @@
// testbench for hash_noise_fbm: drives coordinate beats, predicts each fbm_sum
// with its own fixed-point octave hash and compares results in order
// depends on hnf_pkg and the hash_noise_fbm rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency    = 6 * 16;
  localparam int CycleLimit = 200000;
  localparam int PhaseBeats = 130;
  localparam int HoldCycles = 300;

  localparam logic [31:0] OCT_WEIGHT [16] = '{
    32'd65536,  32'd73921,  32'd83379,  32'd94047,
    32'd106079, 32'd119652, 32'd134961, 32'd152228,
    32'd171705, 32'd193674, 32'd218453, 32'd246403,
    32'd277929, 32'd313489, 32'd353598, 32'd398839
  };

  localparam logic [17:0] CMax = 18'h3FFFF;

  typedef struct packed {
    logic [hnf_pkg::CoordW-1:0] x;
    logic [hnf_pkg::CoordW-1:0] y;
    logic                       known;
    logic [hnf_pkg::SumW-1:0]   sum;
  } corner_t;

  // integer parts zero give the same magnitude, 18467, in every octave
  localparam corner_t CORNERS [20] = '{
    '{18'h00000, 18'h00000, 1'b1, 22'd846441},
    '{18'h000FF, 18'h000FF, 1'b1, 22'd846441},
    '{18'h00000, 18'h000FF, 1'b1, 22'd846441},
    '{CMax,      CMax,      1'b0, 22'd0},
    '{CMax,      18'h00000, 1'b0, 22'd0},
    '{18'h00000, CMax,      1'b0, 22'd0},
    '{18'h00100, 18'h00000, 1'b0, 22'd0},
    '{18'h00000, 18'h00100, 1'b0, 22'd0},
    '{18'h00100, 18'h00100, 1'b0, 22'd0},
    '{18'h2AAAA, 18'h15555, 1'b0, 22'd0},
    '{18'h15555, 18'h2AAAA, 1'b0, 22'd0},
    '{18'h3FF00, 18'h3FF00, 1'b0, 22'd0},
    '{18'h20000, 18'h20000, 1'b0, 22'd0},
    '{18'h1FFFF, 18'h1FFFF, 1'b0, 22'd0},
    '{18'h00355, 18'h00000, 1'b0, 22'd0},
    '{18'h00000, 18'h00355, 1'b0, 22'd0},
    '{18'h03900, 18'h00100, 1'b0, 22'd0},
    '{18'h0C6A0, 18'h2F1E7, 1'b0, 22'd0},
    '{18'h3FFFF, 18'h20000, 1'b0, 22'd0},
    '{18'h000FF, 18'h3FF00, 1'b0, 22'd0}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       coord_valid = 1'b0;
  logic                       coord_ready;
  logic [hnf_pkg::CoordW-1:0] coord_x = '0;
  logic [hnf_pkg::CoordW-1:0] coord_y = '0;
  logic                       fbm_valid;
  logic                       fbm_ready = 1'b0;
  logic [hnf_pkg::SumW-1:0]   fbm_sum;

  logic [hnf_pkg::SumW-1:0] sum_due [$];
  int unsigned send_idle = 22;
  int unsigned recv_idle = 60;
  logic        long_hold = 1'b0;
  int          errors = 0;
  int          sums_checked = 0;
  int          beats_sent = 0;
  int          cycles = 0;

  hash_noise_fbm u_top (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_ready (coord_ready),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .fbm_valid   (fbm_valid),
    .fbm_ready   (fbm_ready),
    .fbm_sum     (fbm_sum)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] octave_mag(input logic [31:0] ix, input logic [31:0] iy);
    logic [31:0] n;
    logic [31:0] m;
    logic [31:0] q;
    n = ix + iy * 32'd57;
    n = (n << 1) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
    q = m >> 14;
    return (q <= 32'd65536) ? 32'd65536 - q : q - 32'd65536;
  endfunction

  function automatic logic [hnf_pkg::SumW-1:0] fbm_of(input logic [17:0] cx,
                                                      input logic [17:0] cy);
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] term;
    logic [63:0] total;
    x = 32'(cx);
    y = 32'(cy);
    total = '0;
    for (int i = 0; i < 16; i++) begin
      term = 64'(octave_mag(x >> 8, y >> 8));
      term = term * 64'(OCT_WEIGHT[i]);
      total = total + (term >> 16);
      x = (x * 32'd3) / 32'd10;
      y = (y * 32'd3) / 32'd10;
    end
    if (total > 64'h3FFFFF) total = 64'h3FFFFF;
    return total[hnf_pkg::SumW-1:0];
  endfunction

  task automatic offer(input logic [17:0] x, input logic [17:0] y,
                       input logic known, input logic [21:0] sum);
    while ($urandom_range(99) < send_idle) begin
      coord_valid <= 1'b0;
      @(posedge clk);
    end
    coord_valid <= 1'b1;
    coord_x     <= x;
    coord_y     <= y;
    @(posedge clk);
    while (!coord_ready) @(posedge clk);
    sum_due.push_back(known ? sum : fbm_of(x, y));
    beats_sent++;
  endtask

  task automatic drain_pause();
    coord_valid <= 1'b0;
    while (sum_due.size() != 0) @(posedge clk);
  endtask

  // sink side, with one long hold-off to back the chain up
  initial begin : sink
    forever begin
      @(posedge clk);
      if (long_hold) begin
        fbm_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        long_hold <= 1'b0;
      end else begin
        fbm_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && fbm_valid && fbm_ready) begin
      if (sum_due.size() == 0) begin
        $display("%0t: fbm_sum %0d with no beat outstanding", $time, fbm_sum);
        errors++;
      end else begin
        if (fbm_sum !== sum_due[0]) begin
          $display("%0t: fbm_sum expected %0d got %0d", $time, sum_due[0], fbm_sum);
          errors++;
        end
        void'(sum_due.pop_front());
        sums_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d sums outstanding", $time, sum_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [17:0] rx;
    logic [17:0] ry;
    int unsigned pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (CORNERS[i]) begin
      offer(CORNERS[i].x, CORNERS[i].y, CORNERS[i].known, CORNERS[i].sum);
    end
    drain_pause();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 22;
          recv_idle = 60;
        end
        1: begin
          send_idle = 60;
          recv_idle = 22;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          long_hold <= 1'b1;
        end
      endcase
      repeat (PhaseBeats) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          rx = 18'($urandom_range(262143));
          ry = 18'($urandom_range(262143));
        end else if (pick < 65) begin
          rx = 18'($urandom_range(4095));
          ry = 18'($urandom_range(4095));
        end else if (pick < 80) begin
          rx = 18'(CMax - $urandom_range(1023));
          ry = 18'(CMax - $urandom_range(1023));
        end else begin
          rx = $urandom_range(1) ? CMax : 18'h0;
          ry = 18'($urandom_range(262143));
          if ($urandom_range(1)) begin
            ry = rx;
            rx = 18'($urandom_range(262143));
          end
        end
        offer(rx, ry, 1'b0, '0);
      end
      drain_pause();
    end

    repeat (Latency + 20) @(posedge clk);
    $display("%0d coordinate beats sent, %0d sums checked in order", beats_sent, sums_checked);
    $display("covered corners, three idle mixes, a full-chain stall and drain pauses");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
